// ===== design/mrbs_pkg.sv =====
// shared types and constants for the masked region band statistics block
`default_nettype none
package mrbs_pkg;

   localparam int REGION_COUNT = 8;
   localparam int BAND_COUNT   = 256;
   localparam int REGION_W     = 3;
   localparam int BAND_W       = 8;
   localparam int ADDR_W       = REGION_W + BAND_W;
   localparam int SAMPLE_W     = 16;
   localparam int COUNT_W      = 20;
   localparam int SUM_W        = SAMPLE_W + COUNT_W;
   localparam int SQSUM_W      = 52;
   localparam int SQ_SAMPLE_W  = 32;
   localparam int PROD_W       = COUNT_W + SQSUM_W;
   localparam int RAD_W        = PROD_W + 2;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int SQREM_W      = ROOT_W + 3;
   localparam int DIV_W        = SUM_W + 2;
   localparam int STEP_W       = 6;
   localparam int BANDS_CFG_W  = 9;
   localparam int REGIONS_CFG_W = 4;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 9;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BANDS_IN_USE   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REGIONS_IN_USE = 1'b1;

   localparam logic [BANDS_CFG_W-1:0]   BANDS_RESET   = 9'd256;
   localparam logic [REGIONS_CFG_W-1:0] REGIONS_RESET = 4'd8;

   // action codes of a request beat
   localparam logic [1:0] ACT_CLEAR  = 2'd0;
   localparam logic [1:0] ACT_ACCUM  = 2'd1;
   localparam logic [1:0] ACT_READ   = 2'd2;

   typedef enum logic [1:0] {
      OP_CLEAR     = 2'd0,
      OP_ACCUM     = 2'd1,
      OP_READ      = 2'd2,
      OP_READ_ZERO = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]                 action;
      logic signed [SAMPLE_W-1:0] sample_value;
      logic [BAND_W-1:0]          band_index;
      logic [REGION_COUNT-1:0]    region_mask;
      logic [REGION_W-1:0]        region_index;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] mean_value;
      logic [SAMPLE_W-1:0]        std_value;
      logic [COUNT_W-1:0]         sample_count;
      logic                       count_overflow;
   } rsp_type;

   typedef struct packed {
      op_type                     op;
      logic signed [SAMPLE_W-1:0] sample;
      logic [BAND_W-1:0]          band;
      logic [REGION_COUNT-1:0]    mask;
      logic [REGION_W-1:0]        region;
   } item_type;

   typedef struct packed {
      logic               ovf;
      logic [COUNT_W-1:0] cnt;
      logic [SQSUM_W-1:0] sqsum;
      logic [SUM_W-1:0]   sum;
   } entry_type;

endpackage
`default_nettype wire

// ===== design/mrbs_front.sv =====
// front end: config registers, request classification and the item queue
`default_nettype none
module mrbs_front (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  push,
   output logic                                       full,
   input  wire mrbs_pkg::req_type                     req_data,
   input  wire logic                                  csr_we,
   input  wire logic [mrbs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [mrbs_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output logic                                       item_valid,
   output mrbs_pkg::item_type                         item,
   input  wire logic                                  item_take
);

   logic [mrbs_pkg::BANDS_CFG_W-1:0]   bands_ff;
   logic [mrbs_pkg::REGIONS_CFG_W-1:0] regions_ff;
   mrbs_pkg::item_type                 q_ff [2];
   logic                               wr_ptr_ff, wr_ptr_in;
   logic                               rd_ptr_ff, rd_ptr_in;
   logic [1:0]                         count_ff, count_in;

   logic                               band_ok, region_ok, keep, enq;
   logic [mrbs_pkg::REGION_COUNT-1:0]  honour;
   mrbs_pkg::item_type                 cls;

   always_ff @(posedge clock) begin
      if (reset) begin
         bands_ff   <= mrbs_pkg::BANDS_RESET;
         regions_ff <= mrbs_pkg::REGIONS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            mrbs_pkg::CSR_BANDS_IN_USE: bands_ff <= csr_wdata;
            mrbs_pkg::CSR_REGIONS_IN_USE:
               regions_ff <= csr_wdata[mrbs_pkg::REGIONS_CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // classify while the beat comes in
   always_comb begin
      for (int r = 0; r < mrbs_pkg::REGION_COUNT; r++) begin
         honour[r] = mrbs_pkg::REGIONS_CFG_W'(r) < regions_ff;
      end
      band_ok   = {1'b0, req_data.band_index} < bands_ff;
      region_ok = {1'b0, req_data.region_index} < regions_ff;
      cls.sample = req_data.sample_value;
      cls.band   = req_data.band_index;
      cls.mask   = req_data.region_mask & honour;
      cls.region = req_data.region_index;
      cls.op     = mrbs_pkg::OP_CLEAR;
      keep       = 1'b0;
      case (req_data.action)
         mrbs_pkg::ACT_CLEAR: begin
            cls.op = mrbs_pkg::OP_CLEAR;
            keep   = 1'b1;
         end
         mrbs_pkg::ACT_ACCUM: begin
            cls.op = mrbs_pkg::OP_ACCUM;
            keep   = band_ok && (cls.mask != '0);
         end
         mrbs_pkg::ACT_READ: begin
            cls.op = (band_ok && region_ok) ? mrbs_pkg::OP_READ : mrbs_pkg::OP_READ_ZERO;
            keep   = 1'b1;
         end
         default: keep = 1'b0;
      endcase
   end

   assign full       = (count_ff == 2'd2);
   assign enq        = push && !full && keep;
   assign item_valid = (count_ff != 2'd0);
   assign item       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = enq ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(enq) - 2'(item_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

endmodule
`default_nettype wire

// ===== design/mrbs_back.sv =====
// back end: accumulator memory, update sequencer and serial arithmetic for reads
`default_nettype none
module mrbs_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               item_valid,
   input  wire mrbs_pkg::item_type item,
   output logic                    item_take,
   output logic                    rsp_push,
   output mrbs_pkg::rsp_type       rsp_item,
   input  wire logic               rsp_full
);

   typedef enum logic [10:0] {
      ST_SWEEP    = 11'b00000000001,
      ST_IDLE     = 11'b00000000010,
      ST_ACC_SCAN = 11'b00000000100,
      ST_ACC_UPD  = 11'b00000001000,
      ST_RD_WAIT  = 11'b00000010000,
      ST_DIV      = 11'b00000100000,
      ST_MUL1     = 11'b00001000000,
      ST_MUL2     = 11'b00010000000,
      ST_SUB      = 11'b00100000000,
      ST_SQRT     = 11'b01000000000,
      ST_EMIT     = 11'b10000000000
   } state_type;

   localparam int AW = mrbs_pkg::ADDR_W;

   mrbs_pkg::entry_type mem [2**AW];
   mrbs_pkg::entry_type rd_data_ff;

   state_type                            state_ff, state_in;
   logic [AW-1:0]                        sweep_ff, sweep_in;
   mrbs_pkg::item_type                   item_ff, item_in;
   logic [mrbs_pkg::SQ_SAMPLE_W-1:0]     sq_sample_ff, sq_sample_in;
   logic [mrbs_pkg::REGION_W-1:0]        ridx_ff, ridx_in;
   logic [mrbs_pkg::COUNT_W-1:0]         n_ff, n_in;
   logic [mrbs_pkg::SUM_W-1:0]           mag_ff, mag_in;
   logic                                 neg_ff, neg_in;
   logic [mrbs_pkg::SQSUM_W-1:0]         sqsum_ff, sqsum_in;
   logic                                 ovf_ff, ovf_in;
   logic [mrbs_pkg::SAMPLE_W-1:0]        mean_ff, mean_in;
   logic [mrbs_pkg::DIV_W-1:0]           div_num_ff, div_num_in;
   logic [mrbs_pkg::COUNT_W-1:0]         div_rem_ff, div_rem_in;
   logic [mrbs_pkg::STEP_W-1:0]          step_ff, step_in;
   logic                                 div_std_ff, div_std_in;
   logic [mrbs_pkg::PROD_W-1:0]          acc_ff, acc_in;
   logic [mrbs_pkg::PROD_W-1:0]          d_ff, d_in;
   logic [mrbs_pkg::RAD_W-1:0]           rad_ff, rad_in;
   logic [mrbs_pkg::ROOT_W-1:0]          root_ff, root_in;
   logic [mrbs_pkg::SQREM_W-1:0]         sqrem_ff, sqrem_in;
   mrbs_pkg::rsp_type                    rsp_ff, rsp_in;

   logic                                 mem_rd, mem_wr;
   logic [AW-1:0]                        mem_raddr, mem_waddr;
   mrbs_pkg::entry_type                  mem_wdata;

   always_comb begin
      logic [mrbs_pkg::SAMPLE_W:0]         smag;
      logic [2*mrbs_pkg::SAMPLE_W+1:0]     sprod;
      mrbs_pkg::entry_type                 e;
      logic [mrbs_pkg::COUNT_W:0]          rem_t;
      logic [mrbs_pkg::DIV_W-1:0]          quo;
      logic [mrbs_pkg::SQREM_W-1:0]        srem_t, trial;
      logic [mrbs_pkg::ROOT_W-1:0]         root_fin;
      logic [mrbs_pkg::SUM_W-1:0]          emag;

      state_in     = state_ff;
      sweep_in     = sweep_ff;
      item_in      = item_ff;
      sq_sample_in = sq_sample_ff;
      ridx_in      = ridx_ff;
      n_in         = n_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      sqsum_in     = sqsum_ff;
      ovf_in       = ovf_ff;
      mean_in      = mean_ff;
      div_num_in   = div_num_ff;
      div_rem_in   = div_rem_ff;
      step_in      = step_ff;
      div_std_in   = div_std_ff;
      acc_in       = acc_ff;
      d_in         = d_ff;
      rad_in       = rad_ff;
      root_in      = root_ff;
      sqrem_in     = sqrem_ff;
      rsp_in       = rsp_ff;
      item_take    = 1'b0;
      rsp_push     = 1'b0;
      mem_rd       = 1'b0;
      mem_wr       = 1'b0;
      mem_raddr    = {item_ff.region, item_ff.band};
      mem_waddr    = {ridx_ff, item_ff.band};
      mem_wdata    = '0;
      smag         = '0;
      sprod        = '0;
      e            = rd_data_ff;
      rem_t        = '0;
      quo          = '0;
      srem_t       = '0;
      trial        = '0;
      root_fin     = '0;
      emag         = '0;

      case (state_ff)
         ST_SWEEP: begin
            mem_wr    = 1'b1;
            mem_waddr = sweep_ff;
            mem_wdata = '0;
            sweep_in  = sweep_ff + AW'(1);
            if (sweep_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               item_take = 1'b1;
               item_in   = item;
               smag = item.sample[mrbs_pkg::SAMPLE_W-1]
                    ? (17'd0 - {item.sample[mrbs_pkg::SAMPLE_W-1], item.sample})
                    : {1'b0, item.sample};
               sprod        = smag * smag;
               sq_sample_in = sprod[mrbs_pkg::SQ_SAMPLE_W-1:0];
               ridx_in      = '0;
               case (item.op)
                  mrbs_pkg::OP_CLEAR: begin
                     sweep_in = '0;
                     state_in = ST_SWEEP;
                  end
                  mrbs_pkg::OP_ACCUM: state_in = ST_ACC_SCAN;
                  mrbs_pkg::OP_READ: begin
                     mem_rd    = 1'b1;
                     mem_raddr = {item.region, item.band};
                     state_in  = ST_RD_WAIT;
                  end
                  default: begin
                     rsp_in   = '0;
                     state_in = ST_EMIT;
                  end
               endcase
            end
         end
         ST_ACC_SCAN: begin
            if (item_ff.mask[ridx_ff]) begin
               mem_rd    = 1'b1;
               mem_raddr = {ridx_ff, item_ff.band};
               state_in  = ST_ACC_UPD;
            end else if (ridx_ff == '1) begin
               state_in = ST_IDLE;
            end else begin
               ridx_in = ridx_ff + 3'd1;
            end
         end
         ST_ACC_UPD: begin
            mem_wr    = 1'b1;
            mem_wdata = e;
            if (e.cnt == '1) begin
               mem_wdata.ovf = 1'b1;
            end else begin
               mem_wdata.sum = e.sum + {{mrbs_pkg::COUNT_W{item_ff.sample[15]}},
                                        item_ff.sample};
               mem_wdata.sqsum = e.sqsum + mrbs_pkg::SQSUM_W'(sq_sample_ff);
               mem_wdata.cnt   = e.cnt + mrbs_pkg::COUNT_W'(1);
            end
            if (ridx_ff == '1) begin
               state_in = ST_IDLE;
            end else begin
               ridx_in  = ridx_ff + 3'd1;
               state_in = ST_ACC_SCAN;
            end
         end
         ST_RD_WAIT: begin
            emag     = e.sum[mrbs_pkg::SUM_W-1] ? (mrbs_pkg::SUM_W'(0) - e.sum) : e.sum;
            n_in     = e.cnt;
            ovf_in   = e.ovf;
            neg_in   = e.sum[mrbs_pkg::SUM_W-1];
            mag_in   = emag;
            sqsum_in = e.sqsum;
            if (e.cnt == '0) begin
               rsp_in = '{mean_value: '0, std_value: '0, sample_count: '0,
                          count_overflow: e.ovf};
               state_in = ST_EMIT;
            end else begin
               div_num_in = mrbs_pkg::DIV_W'(emag) + mrbs_pkg::DIV_W'(e.cnt >> 1);
               div_rem_in = '0;
               step_in    = '0;
               div_std_in = 1'b0;
               state_in   = ST_DIV;
            end
         end
         ST_DIV: begin
            // restoring divide, one quotient bit a cycle
            rem_t = {div_rem_ff, div_num_ff[mrbs_pkg::DIV_W-1]};
            if (rem_t >= {1'b0, n_ff}) begin
               div_rem_in = mrbs_pkg::COUNT_W'(rem_t - {1'b0, n_ff});
               div_num_in = {div_num_ff[mrbs_pkg::DIV_W-2:0], 1'b1};
            end else begin
               div_rem_in = rem_t[mrbs_pkg::COUNT_W-1:0];
               div_num_in = {div_num_ff[mrbs_pkg::DIV_W-2:0], 1'b0};
            end
            step_in = step_ff + mrbs_pkg::STEP_W'(1);
            quo     = div_num_in;
            if (step_ff == mrbs_pkg::STEP_W'(mrbs_pkg::DIV_W - 1)) begin
               if (!div_std_ff) begin
                  if (neg_ff) begin
                     mean_in = (quo > mrbs_pkg::DIV_W'(32768)) ? 16'h8000
                             : 16'(16'd0 - quo[mrbs_pkg::SAMPLE_W-1:0]);
                  end else begin
                     mean_in = (quo > mrbs_pkg::DIV_W'(32767)) ? 16'h7fff
                             : quo[mrbs_pkg::SAMPLE_W-1:0];
                  end
                  acc_in   = '0;
                  step_in  = mrbs_pkg::STEP_W'(mrbs_pkg::COUNT_W - 1);
                  state_in = ST_MUL1;
               end else begin
                  rsp_in.mean_value     = mean_ff;
                  rsp_in.std_value      = (quo > mrbs_pkg::DIV_W'(16'hffff)) ? 16'hffff
                                        : quo[mrbs_pkg::SAMPLE_W-1:0];
                  rsp_in.sample_count   = n_ff;
                  rsp_in.count_overflow = ovf_ff;
                  state_in              = ST_EMIT;
               end
            end
         end
         ST_MUL1: begin
            // count times sum of squares, shift and add
            acc_in = {acc_ff[mrbs_pkg::PROD_W-2:0], 1'b0}
                   + (n_ff[step_ff[4:0]] ? mrbs_pkg::PROD_W'(sqsum_ff) : '0);
            step_in = step_ff - mrbs_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               d_in     = acc_in;
               acc_in   = '0;
               step_in  = mrbs_pkg::STEP_W'(mrbs_pkg::SUM_W - 1);
               state_in = ST_MUL2;
            end
         end
         ST_MUL2: begin
            // square of the sum magnitude
            acc_in = {acc_ff[mrbs_pkg::PROD_W-2:0], 1'b0}
                   + (mag_ff[step_ff] ? mrbs_pkg::PROD_W'(mag_ff) : '0);
            step_in = step_ff - mrbs_pkg::STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB: begin
            rad_in   = (d_ff > acc_ff) ? {d_ff - acc_ff, 2'b00} : '0;
            root_in  = '0;
            sqrem_in = '0;
            step_in  = '0;
            state_in = ST_SQRT;
         end
         ST_SQRT: begin
            // digit recurrence, one root bit a cycle
            srem_t = {sqrem_ff[mrbs_pkg::SQREM_W-3:0], rad_ff[mrbs_pkg::RAD_W-1 -: 2]};
            trial  = {1'b0, root_ff, 2'b01};
            rad_in = {rad_ff[mrbs_pkg::RAD_W-3:0], 2'b00};
            if (srem_t >= trial) begin
               sqrem_in = srem_t - trial;
               root_in  = {root_ff[mrbs_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               sqrem_in = srem_t;
               root_in  = {root_ff[mrbs_pkg::ROOT_W-2:0], 1'b0};
            end
            step_in  = step_ff + mrbs_pkg::STEP_W'(1);
            root_fin = root_in;
            if (step_ff == mrbs_pkg::STEP_W'(mrbs_pkg::ROOT_W - 1)) begin
               // round half of the root over the count
               div_num_in = mrbs_pkg::DIV_W'(root_fin >> 1)
                          + mrbs_pkg::DIV_W'(n_ff >> 1)
                          + mrbs_pkg::DIV_W'(root_fin[0] & n_ff[0]);
               div_rem_in = '0;
               step_in    = '0;
               div_std_in = 1'b1;
               state_in   = ST_DIV;
            end
         end
         ST_EMIT: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_item = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
         sweep_ff <= '0;
      end else begin
         state_ff <= state_in;
         sweep_ff <= sweep_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      sq_sample_ff <= sq_sample_in;
      ridx_ff      <= ridx_in;
      n_ff         <= n_in;
      mag_ff       <= mag_in;
      neg_ff       <= neg_in;
      sqsum_ff     <= sqsum_in;
      ovf_ff       <= ovf_in;
      mean_ff      <= mean_in;
      div_num_ff   <= div_num_in;
      div_rem_ff   <= div_rem_in;
      step_ff      <= step_in;
      div_std_ff   <= div_std_in;
      acc_ff       <= acc_in;
      d_ff         <= d_in;
      rad_ff       <= rad_in;
      root_ff      <= root_in;
      sqrem_ff     <= sqrem_in;
      rsp_ff       <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_rd) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

`ifndef NO_ASSERTIONS
   a_div_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> div_rem_ff < n_ff)
      else $error("divider remainder not below count");

   a_sqrt_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SQRT |-> sqrem_ff <= {2'b00, root_ff, 1'b0})
      else $error("root remainder above twice the partial root");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ACC_UPD && rd_data_ff.ovf) |-> mem_wdata.ovf)
      else $error("accumulate cleared an overflow flag");

   a_count_monotonic: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC_UPD |-> mem_wdata.cnt >= rd_data_ff.cnt)
      else $error("accumulate lowered a count");
`endif

endmodule
`default_nettype wire

// ===== design/mrbs_out.sv =====
// two-entry result queue toward the consumer
`default_nettype none
module mrbs_out (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_push,
   input  wire mrbs_pkg::rsp_type in_data,
   output logic                   in_full,
   output logic                   empty,
   input  wire logic              pop,
   output mrbs_pkg::rsp_type      rsp_data
);

   mrbs_pkg::rsp_type q_ff [2];
   logic              wr_ptr_ff, rd_ptr_ff;
   logic [1:0]        count_ff, count_in;
   logic              deq;

   assign in_full  = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign deq      = pop && !empty;
   assign rsp_data = q_ff[rd_ptr_ff];
   assign count_in = count_ff + 2'(in_push) - 2'(deq);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (in_push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (deq) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_push) begin
         q_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

// ===== design/masked_region_band_statistics.sv =====
// masked region band statistics: top level joining front end, back end and result queue
// accumulate: regions scanned in turn, a read and write per set and honoured region bit
// read: a 38-step divide, 20- and 36-step multiplies, a 37-step root, a 38-step divide
// read of an empty entry, or of a band or region out of use, skips the arithmetic
// clear: one memory entry zeroed per cycle; no items taken meanwhile
// after reset the same clearing pass runs before the first item is taken
// one item in the back end at a time; up to two queued in front, two results behind
`default_nettype none
module masked_region_band_statistics (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request side
   input  wire logic                            push,
   output logic                                 full,
   input  wire mrbs_pkg::req_type               req_data,
   // result side
   output logic                                 empty,
   input  wire logic                            pop,
   output mrbs_pkg::rsp_type                    rsp_data,
   // register writes
   input  wire logic                            csr_we,
   input  wire logic [mrbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mrbs_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // classified items between front and back
   logic               item_valid;
   logic               item_take;
   mrbs_pkg::item_type item;

   // results from back to the output queue
   logic               rsp_push;
   logic               rsp_full;
   mrbs_pkg::rsp_type  rsp_item;

   // front classifies beats against bands and regions in use, drops no-ops
   mrbs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take)
   );

   // back holds the accumulator memory and the read arithmetic
   mrbs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_item),
      .rsp_full   (rsp_full)
   );

   // finished results wait here so the back end keeps going
   mrbs_out u_out (
      .clock    (clock),
      .reset    (reset),
      .in_push  (rsp_push),
      .in_data  (rsp_item),
      .in_full  (rsp_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire
